FILE: rtl/gdn_pkg.sv
// gdn_pkg: shared types, constants, month tables and microcode rom of the day number converter
package gdn_pkg;

    localparam int PC_W    = 4;
    localparam int KW      = 4;
    localparam int CONST_W = 18;
    localparam int REM_W   = 32;
    localparam int SH_W    = 34;
    localparam int ACC_W   = 36;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CONST_W-1:0] DAYS_400 = 18'd146097;
    localparam logic [CONST_W-1:0] DAYS_100 = 18'd36524;
    localparam logic [CONST_W-1:0] DAYS_4   = 18'd1461;
    localparam logic [CONST_W-1:0] DAYS_1   = 18'd365;

    // negative day counts are lifted by 14700 whole 400-year cycles
    localparam logic [REM_W-1:0]        D2D_BIAS     = 32'd2147625900;
    localparam logic signed [ACC_W-1:0] YEAR_NEG0    = -36'sd5879999;
    localparam logic signed [ACC_W-1:0] YEAR_POS0    = 36'sd1;
    // month minus one lifted by 342 years of months
    localparam logic [REM_W-1:0]        M_BIAS       = 32'd4103;
    localparam logic signed [ACC_W-1:0] YEAR_M_BIAS  = 36'sd342;
    // year minus one lifted by 20973 whole 400-year cycles
    localparam logic signed [ACC_W-1:0] P_BIAS       = 36'sd8389199;
    localparam logic signed [ACC_W-1:0] DAY_BIAS     = 36'sd3064092382;
    localparam logic signed [ACC_W-1:0] NUM_LO       = -36'sd2147483647;
    localparam logic signed [ACC_W-1:0] NUM_HI       = 36'sd2147483647;
    localparam logic [31:0]             NUM_ABSENT   = 32'h8000_0000;

    localparam logic [1:0] CNT_FULL  = 2'd3;
    localparam logic [4:0] QUAD_CENT = 5'd24;
    localparam logic [3:0] MON_LAST  = 4'd11;

    typedef enum logic [2:0] {
        U_LOAD = 3'd0,
        U_DIV  = 3'd1,
        U_REP  = 3'd2,
        U_MON  = 3'd3,
        U_LDP  = 3'd4,
        U_CUM  = 3'd5,
        U_DONE = 3'd6
    } uop_t;

    typedef enum logic [1:0] {
        J_NEXT  = 2'd0,
        J_OP    = 2'd1,
        J_LOOPK = 2'd2,
        J_LOOPF = 2'd3
    } jmp_t;

    typedef enum logic [1:0] {
        CL_NONE = 2'd0,
        CL_HUND = 2'd1,
        CL_QUAD = 2'd2,
        CL_ONE  = 2'd3
    } cls_t;

    typedef struct packed {
        uop_t               uop;
        jmp_t               jmp;
        cls_t               cls;
        logic [KW-1:0]      kinit;
        logic [CONST_W-1:0] dvs;
        logic [CONST_W-1:0] inc;
        logic [PC_W-1:0]    tgt;
    } uword_t;

    typedef struct packed {
        logic          en;
        uword_t        w;
        logic [KW-1:0] k;
    } ctl_t;

    typedef struct packed {
        logic hit;
    } dp_flag_t;

    typedef struct packed {
        logic [31:0] num;
        logic [23:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        status;
    } res_t;

    localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
    localparam logic [PC_W-1:0] PC_Y400  = 4'd1;
    localparam logic [PC_W-1:0] PC_Y100  = 4'd2;
    localparam logic [PC_W-1:0] PC_Y4    = 4'd3;
    localparam logic [PC_W-1:0] PC_Y1    = 4'd4;
    localparam logic [PC_W-1:0] PC_MON   = 4'd5;
    localparam logic [PC_W-1:0] PC_MDIV  = 4'd6;
    localparam logic [PC_W-1:0] PC_LDP   = 4'd7;
    localparam logic [PC_W-1:0] PC_D400  = 4'd8;
    localparam logic [PC_W-1:0] PC_D100  = 4'd9;
    localparam logic [PC_W-1:0] PC_D4    = 4'd10;
    localparam logic [PC_W-1:0] PC_D1    = 4'd11;
    localparam logic [PC_W-1:0] PC_CUM   = 4'd12;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd13;

    function automatic uword_t gdn_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        w = '{U_DONE, J_NEXT, CL_NONE, 4'd0, 18'd0, 18'd0, PC_LOAD};
        case (addr)
            PC_LOAD: w = '{U_LOAD, J_OP,    CL_NONE, 4'd0,  18'd0,    18'd0,    PC_MDIV};
            PC_Y400: w = '{U_DIV,  J_LOOPK, CL_NONE, 4'd14, DAYS_400, 18'd400,  PC_Y100};
            PC_Y100: w = '{U_REP,  J_LOOPF, CL_HUND, 4'd0,  DAYS_100, 18'd100,  PC_Y4};
            PC_Y4:   w = '{U_DIV,  J_LOOPK, CL_QUAD, 4'd4,  DAYS_4,   18'd4,    PC_Y1};
            PC_Y1:   w = '{U_REP,  J_LOOPF, CL_ONE,  4'd0,  DAYS_1,   18'd1,    PC_MON};
            PC_MON:  w = '{U_MON,  J_LOOPF, CL_NONE, 4'd0,  18'd0,    18'd0,    PC_DONE};
            PC_MDIV: w = '{U_DIV,  J_LOOPK, CL_NONE, 4'd9,  18'd12,   18'd1,    PC_LDP};
            PC_LDP:  w = '{U_LDP,  J_NEXT,  CL_NONE, 4'd0,  18'd0,    18'd0,    PC_D400};
            PC_D400: w = '{U_DIV,  J_LOOPK, CL_NONE, 4'd15, 18'd400,  DAYS_400, PC_D100};
            PC_D100: w = '{U_REP,  J_LOOPF, CL_HUND, 4'd0,  18'd100,  DAYS_100, PC_D4};
            PC_D4:   w = '{U_DIV,  J_LOOPK, CL_QUAD, 4'd4,  18'd4,    DAYS_4,   PC_D1};
            PC_D1:   w = '{U_REP,  J_LOOPF, CL_ONE,  4'd0,  18'd1,    DAYS_1,   PC_CUM};
            PC_CUM:  w = '{U_CUM,  J_NEXT,  CL_NONE, 4'd0,  18'd0,    18'd0,    PC_DONE};
            PC_DONE: w = '{U_DONE, J_NEXT,  CL_NONE, 4'd0,  18'd0,    18'd0,    PC_LOAD};
            default: w = '{U_DONE, J_NEXT,  CL_NONE, 4'd0,  18'd0,    18'd0,    PC_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] gdn_month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] gdn_cum_days(input logic leap, input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd59;
            4'd3:    c = 9'd90;
            4'd4:    c = 9'd120;
            4'd5:    c = 9'd151;
            4'd6:    c = 9'd181;
            4'd7:    c = 9'd212;
            4'd8:    c = 9'd243;
            4'd9:    c = 9'd273;
            4'd10:   c = 9'd304;
            default: c = 9'd334;
        endcase
        if (leap && (m >= 4'd2)) begin
            c = c + 9'd1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/gregorian_day_number_converter_unit.sv
// gregorian_day_number_converter_unit: top level of the day count and civil date converter
//
// channel  | valid/ready         | tuser              | tdata (lowest bit up)
// request  | s_tvalid / s_tready | operation          | day_number_in, year_in, month_in, day_in
// result   | m_tvalid / m_tready | status             | day_number_out, year_out, month_out, day_out
//
// one request at a time, one microcode step a cycle except while the done step waits for a free output
// the work is done by the shift-subtract and repeat loops of the compare/subtract unit
// s_tready is high while the sequencer sits on its load step, also while a result waits
// a result that is not taken holds the sequencer on its done step
// synchronous active-low reset returns the sequencer to the load step and empties the output
module gregorian_day_number_converter_unit import gdn_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,  // operation
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // day_number_in, year_in, month_in, day_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tuser,  // status
    output logic [OUT_TDATA_W-1:0] m_tdata   // day_number_out, year_out, month_out, day_out
);

    ctl_t     ctl;
    dp_flag_t flag;
    res_t     res;
    logic     idle;
    logic     out_free;
    logic     done_fire;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_user_reg, m_user_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    assign out_free  = !m_valid_reg || m_tready;
    assign done_fire = ctl.en && (ctl.w.uop == U_DONE);

    gdn_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_op    (s_tuser),
        .out_free  (out_free),
        .flag      (flag),
        .ctl       (ctl),
        .idle      (idle)
    );

    gdn_dp u_dp (
        .aclk          (aclk),
        .ctl           (ctl),
        .operation     (s_tuser),
        .day_number_in (s_tdata[31:0]),
        .year_in       (s_tdata[55:32]),
        .month_in      (s_tdata[68:56]),
        .day_in        (s_tdata[85:69]),
        .flag          (flag),
        .res           (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        if (done_fire) begin
            m_valid_next = 1'b1;
            m_user_next  = res.status;
            m_data_next  = {7'd0, res.day, res.month, res.year, res.num};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = idle;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/gdn_seq.sv
// gdn_seq: microcode step counter, loop counter and jump logic
module gdn_seq import gdn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     req_valid,
    input  logic     req_op,
    input  logic     out_free,
    input  dp_flag_t flag,
    output ctl_t     ctl,
    output logic     idle
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [PC_W-1:0] tgt;
    uword_t          w;
    uword_t          nw;
    logic            en;
    logic            stay;

    always_comb begin
        w = gdn_rom(pc_reg);
        case (w.uop)
            U_LOAD:  en = req_valid;
            U_DONE:  en = out_free;
            default: en = 1'b1;
        endcase
        stay = 1'b0;
        tgt  = w.tgt;
        case (w.jmp)
            J_OP:    tgt  = req_op ? w.tgt : pc_reg + 4'd1;
            J_LOOPK: stay = (k_reg != '0);
            J_LOOPF: stay = flag.hit;
            default: stay = 1'b0;
        endcase
        nw      = gdn_rom(tgt);
        pc_next = pc_reg;
        k_next  = k_reg;
        if (en) begin
            if (stay) begin
                if (w.jmp == J_LOOPK) begin
                    k_next = k_reg - 4'd1;
                end
            end else begin
                pc_next = tgt;
                k_next  = nw.kinit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_LOAD;
            k_reg  <= '0;
        end else begin
            pc_reg <= pc_next;
            k_reg  <= k_next;
        end
    end

    assign ctl  = '{en: en, w: w, k: k_reg};
    assign idle = (w.uop == U_LOAD);

endmodule

FILE: rtl/gdn_dp.sv
// gdn_dp: remainder and accumulator datapath with a compare and subtract unit shared by the divide and repeat steps
module gdn_dp import gdn_pkg::*; (
    input  logic               aclk,
    input  ctl_t               ctl,
    input  logic               operation,
    input  logic signed [31:0] day_number_in,
    input  logic signed [23:0] year_in,
    input  logic signed [12:0] month_in,
    input  logic signed [16:0] day_in,
    output dp_flag_t           flag,
    output res_t               res
);

    logic [REM_W-1:0]        rem_reg, rem_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [3:0]              mon_reg, mon_next;
    logic [1:0]              hund_reg, hund_next;
    logic [4:0]              quad_reg, quad_next;
    logic [1:0]              one_reg, one_next;
    logic                    op_reg, op_next;
    logic                    absent_reg, absent_next;
    logic signed [16:0]      day_reg, day_next;

    logic [SH_W-1:0]  dvs_sh;
    logic [ACC_W-1:0] inc_sh;
    logic [ACC_W-1:0] p_sum;
    logic             ge_div;
    logic             cap;
    logic             leap;
    logic [4:0]       mlen;
    logic             ge_mon;
    logic             hit;
    logic             err;

    always_comb begin
        dvs_sh = {{(SH_W-CONST_W){1'b0}}, ctl.w.dvs} << ctl.k;
        inc_sh = {{(ACC_W-CONST_W){1'b0}}, ctl.w.inc} << ctl.k;
        ge_div = {{(SH_W-REM_W){1'b0}}, rem_reg} >= dvs_sh;
        case (ctl.w.cls)
            CL_HUND: cap = (hund_reg == CNT_FULL);
            CL_ONE:  cap = (one_reg == CNT_FULL);
            default: cap = 1'b0;
        endcase
        leap   = (one_reg == CNT_FULL) && ((quad_reg != QUAD_CENT) || (hund_reg == CNT_FULL));
        mlen   = gdn_month_len(leap, mon_reg);
        ge_mon = rem_reg >= {{(REM_W-5){1'b0}}, mlen};
        case (ctl.w.uop)
            U_REP:   hit = ge_div && !cap;
            U_MON:   hit = ge_mon && (mon_reg != MON_LAST);
            default: hit = 1'b0;
        endcase
        p_sum = acc_reg + P_BIAS;
    end

    assign flag.hit = hit;

    always_comb begin
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        mon_next    = mon_reg;
        hund_next   = hund_reg;
        quad_next   = quad_reg;
        one_next    = one_reg;
        op_next     = op_reg;
        absent_next = absent_reg;
        day_next    = day_reg;
        if (ctl.en) begin
            case (ctl.w.uop)
                U_LOAD: begin
                    op_next     = operation;
                    day_next    = day_in;
                    mon_next    = '0;
                    hund_next   = '0;
                    quad_next   = '0;
                    one_next    = '0;
                    absent_next = !operation && (day_number_in == NUM_ABSENT);
                    if (operation) begin
                        rem_next = {{(REM_W-13){month_in[12]}}, month_in} + M_BIAS;
                        acc_next = {{(ACC_W-24){year_in[23]}}, year_in} - YEAR_M_BIAS;
                    end else if (day_number_in[31]) begin
                        rem_next = day_number_in + D2D_BIAS;
                        acc_next = YEAR_NEG0;
                    end else begin
                        rem_next = day_number_in;
                        acc_next = YEAR_POS0;
                    end
                end
                U_DIV: begin
                    if (ge_div) begin
                        rem_next = rem_reg - dvs_sh[REM_W-1:0];
                        acc_next = acc_reg + $signed(inc_sh);
                        if (ctl.w.cls == CL_QUAD) begin
                            quad_next[ctl.k[2:0]] = 1'b1;
                        end
                    end
                end
                U_REP: begin
                    if (hit) begin
                        rem_next = rem_reg - dvs_sh[REM_W-1:0];
                        acc_next = acc_reg + $signed(inc_sh);
                        if (ctl.w.cls == CL_HUND) begin
                            hund_next = hund_reg + 2'd1;
                        end
                        if (ctl.w.cls == CL_ONE) begin
                            one_next = one_reg + 2'd1;
                        end
                    end
                end
                U_MON: begin
                    if (hit) begin
                        rem_next = rem_reg - {{(REM_W-5){1'b0}}, mlen};
                        mon_next = mon_reg + 4'd1;
                    end
                end
                U_LDP: begin
                    rem_next  = p_sum[REM_W-1:0];
                    mon_next  = rem_reg[3:0];
                    acc_next  = {{(ACC_W-17){day_reg[16]}}, day_reg} - DAY_BIAS;
                    hund_next = '0;
                    quad_next = '0;
                    one_next  = '0;
                end
                U_CUM: begin
                    acc_next = acc_reg + {{(ACC_W-9){1'b0}}, gdn_cum_days(leap, mon_reg)};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        mon_reg    <= mon_next;
        hund_reg   <= hund_next;
        quad_reg   <= quad_next;
        one_reg    <= one_next;
        op_reg     <= op_next;
        absent_reg <= absent_next;
        day_reg    <= day_next;
    end

    always_comb begin
        err = (acc_reg < NUM_LO) || (acc_reg > NUM_HI);
        if (op_reg) begin
            res.num    = err ? NUM_ABSENT : acc_reg[31:0];
            res.year   = '0;
            res.month  = '0;
            res.day    = '0;
            res.status = err;
        end else if (absent_reg) begin
            res.num    = '0;
            res.year   = 24'd1;
            res.month  = 4'd1;
            res.day    = 5'd1;
            res.status = 1'b1;
        end else begin
            res.num    = '0;
            res.year   = acc_reg[23:0];
            res.month  = mon_reg + 4'd1;
            res.day    = rem_reg[4:0] + 5'd1;
            res.status = 1'b0;
        end
    end

endmodule

FILE: rtl/gdn_checker.sv
// gdn_checker: port-level checks of the converter and their bind to the top level
module gdn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [71:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // one request in work at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a failed result carries either no count or the absent marker
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && (m_tdata[31:0] != 32'd0) |-> m_tdata[31:0] == 32'h8000_0000)
        else $error("bad count on failed result");

    // a date result has a legal month and day and no count
    a_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[59:56] != 4'd0) |->
            (m_tdata[59:56] <= 4'd12) && (m_tdata[64:60] != 5'd0) && (m_tdata[31:0] == 32'd0))
        else $error("bad date result");

endmodule

bind gregorian_day_number_converter_unit gdn_checker u_gdn_checker (.*);
